/* rtl/res_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// res_pkg
// Types, constants and the long-division step shared by the edge setup pipe.
// ----------------------------------------------------------------------------
package res_pkg;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 216;

  // quotient bits of 2^18 / |dy| and of the 31-bit dividers
  localparam int D1_STEPS = 19;
  localparam int D2_STEPS = 31;

  localparam logic [31:0] ONE_PIX  = 32'h0004_0000;
  localparam logic [31:0] HALF_PIX = 32'h0002_0000;
  localparam logic [29:0] INC_ONE  = 30'h0004_0000;
  localparam logic [6:0]  W_MASK   = 7'h7E;

  typedef struct packed {
    logic               dummy;
    logic               side;
    logic               neg;
    logic               yneg;
    logic               yzero;
    logic               yeqx;
    logic               lin;
    logic [11:0]        x0;
    logic [11:0]        x1;
    logic [11:0]        y0;
    logic [11:0]        y1;
    logic [11:0]        dxabs;
    logic [11:0]        xlen;
    logic [11:0]        yabs;
    logic signed [12:0] xmin;
    logic signed [12:0] xmax;
    logic [14:0]        w0n;
    logic [15:0]        w0d;
    logic [14:0]        w1d;
  } front_t;

  typedef struct packed {
    logic signed [12:0] xmin;
    logic signed [12:0] xmax;
    logic [29:0]        inc;
    logic signed [31:0] dxi;
    logic signed [12:0] i0;
    logic signed [12:0] i1;
    logic               xmaj;
    logic               dneg;
    logic               dzero;
    logic               yneg;
    logic               lin;
    logic [11:0]        dabs;
    logic [11:0]        xlen;
    logic [11:0]        yabs;
    logic [14:0]        w0n;
    logic [15:0]        w0d;
    logic [14:0]        w1d;
  } back_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [12:0] div_step(input logic [11:0] rem, input logic nbit,
                                           input logic [11:0] den);
    logic [12:0] t;
    logic        ge;
    t  = {rem, nbit};
    ge = (t >= {1'b0, den});
    div_step = ge ? {1'b1, 12'(t - {1'b0, den})} : {1'b0, t[11:0]};
  endfunction

endpackage

/* rtl/raster_edge_slope_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_edge_slope_setup
// Per-edge rasterizer setup: x extent, slope, initial x offset, interpolation
// axis with its reciprocal, coverage step and w terms for one polygon edge.
// ----------------------------------------------------------------------------
// throughput: one edge per cycle while the skid register is empty; the 19-step and
//   31-step bit-per-stage dividers set the depth, one 12x19 multiply sits in its own stage
// a result can wait in the output register while one more is caught in the
//   skid register; the pipe freezes only while the skid register is full
// synchronous active-low reset clears all valid bits, data is not reset
module raster_edge_slope_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // x_start[11:0] y_start[23:12] x_end[35:24] y_end[47:36]
  // w_start[63:48] w_end[79:64] right_side[80], zero fill above
  input  logic [res_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // x_min[12:0] x_max[25:13] slope_increment[55:26] dx_initial[87:56]
  // interp_start[100:88] interp_end[113:101] interp_recip[145:114]
  // coverage_increment[168:146] linear_interp[169] w_start_num[184:170]
  // w_start_den[200:185] w_end_den[215:201]
  output logic [res_pkg::OUT_DATA_W-1:0] out_tdata
);
  import res_pkg::*;

  logic en;

  // stage 0
  front_t s0_nxt, s0_r;
  logic   s0_v_r;

  // divider 1: 2^18 / |dy|
  front_t      d1_f_r   [D1_STEPS];
  logic [11:0] d1_rem_r [D1_STEPS];
  logic [18:0] d1_quo_r [D1_STEPS];
  logic        d1_v_r   [D1_STEPS];
  front_t      d1_f_nxt [D1_STEPS];
  logic [11:0] d1_rem_nxt [D1_STEPS];
  logic [18:0] d1_quo_nxt [D1_STEPS];
  logic        d1_v_nxt [D1_STEPS];

  // multiply stage
  front_t      m_r;
  logic [29:0] m_inc_r, m_inc_nxt;
  logic        m_v_r;

  // axis setup stage
  back_t x_r, x_nxt;
  logic  x_v_r;

  // dividers 2 and 3: 2^30 / |axis| and |dy|*1024 / xlen
  back_t       e_b_r   [D2_STEPS];
  logic [11:0] e_r2_r  [D2_STEPS];
  logic [30:0] e_q2_r  [D2_STEPS];
  logic [11:0] e_r3_r  [D2_STEPS];
  logic [30:0] e_q3_r  [D2_STEPS];
  logic        e_v_r   [D2_STEPS];
  back_t       e_b_nxt [D2_STEPS];
  logic [11:0] e_r2_nxt [D2_STEPS];
  logic [30:0] e_q2_nxt [D2_STEPS];
  logic [11:0] e_r3_nxt [D2_STEPS];
  logic [30:0] e_q3_nxt [D2_STEPS];
  logic        e_v_nxt  [D2_STEPS];

  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic                  out_v_r, skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    logic [11:0] x0, y0, x1, y1;
    logic [15:0] w0, w1;
    logic        side, dummy;
    logic signed [12:0] dx, dy;
    x0    = in_tdata[11:0];
    y0    = in_tdata[23:12];
    x1    = in_tdata[35:24];
    y1    = in_tdata[47:36];
    w0    = in_tdata[63:48];
    w1    = in_tdata[79:64];
    side  = in_tdata[80];
    dummy = in_tuser;
    dx    = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy    = $signed({1'b0, y1}) - $signed({1'b0, y0});

    s0_nxt.dummy = dummy;
    s0_nxt.side  = side;
    s0_nxt.x0    = x0;
    s0_nxt.x1    = x1;
    s0_nxt.y0    = y0;
    s0_nxt.y1    = y1;
    s0_nxt.neg   = (x1 < x0);
    s0_nxt.dxabs = dx[12] ? 12'(-dx) : dx[11:0];
    s0_nxt.yneg  = dy[12];
    s0_nxt.yabs  = dy[12] ? 12'(-dy) : dy[11:0];
    s0_nxt.yzero = (dy == 13'sd0);
    if (dummy || x1 == x0) begin
      s0_nxt.xmin = $signed({1'b0, x0}) - $signed({12'd0, side});
      s0_nxt.xmax = s0_nxt.xmin;
      s0_nxt.xlen = 12'd1;
    end else if (x1 > x0) begin
      s0_nxt.xmin = $signed({1'b0, x0});
      s0_nxt.xmax = $signed({1'b0, x1}) - 13'sd1;
      s0_nxt.xlen = 12'(x1 - x0);
    end else begin
      s0_nxt.xmin = $signed({1'b0, x1});
      s0_nxt.xmax = $signed({1'b0, x0}) - 13'sd1;
      s0_nxt.xlen = 12'(x0 - x1);
    end
    s0_nxt.yeqx = !dy[12] && (dy[11:0] == s0_nxt.xlen);

    if (dummy) begin
      s0_nxt.lin = 1'b1;
      s0_nxt.w0n = '0;
      s0_nxt.w0d = '0;
      s0_nxt.w1d = '0;
    end else begin
      s0_nxt.lin = (w0 == w1) && ((w0[6:0] & W_MASK) == '0) && ((w1[6:0] & W_MASK) == '0);
      s0_nxt.w0n = w0[15:1];
      // odd start w with even end w rounds the denominator term up
      s0_nxt.w0d = {1'b0, w0[15:1]} + {15'd0, (w0[0] & ~w1[0])};
      s0_nxt.w1d = w1[15:1];
    end
  end

  // ------------------------------------------------------------- divider 1
  always_comb begin
    logic [12:0] st;
    for (int k = 0; k < D1_STEPS; k++) begin
      if (k == 0) begin
        st            = div_step(12'd0, 1'b1, s0_r.yabs);
        d1_f_nxt[k]   = s0_r;
        d1_v_nxt[k]   = s0_v_r;
        d1_quo_nxt[k] = {18'd0, st[12]};
      end else begin
        st            = div_step(d1_rem_r[k-1], 1'b0, d1_f_r[k-1].yabs);
        d1_f_nxt[k]   = d1_f_r[k-1];
        d1_v_nxt[k]   = d1_v_r[k-1];
        d1_quo_nxt[k] = {d1_quo_r[k-1][17:0], st[12]};
      end
      d1_rem_nxt[k] = st[11:0];
    end
  end

  // ------------------------------------------------------------ multiply
  always_comb begin
    front_t f;
    logic [30:0] prod;
    f    = d1_f_r[D1_STEPS-1];
    prod = 31'(f.dxabs * d1_quo_r[D1_STEPS-1]);
    if (f.dummy || f.yzero) m_inc_nxt = '0;
    else if (f.yeqx)        m_inc_nxt = INC_ONE;
    else                    m_inc_nxt = prod[29:0];
  end

  // ---------------------------------------------------------- axis setup
  always_comb begin
    logic signed [12:0] d;
    logic               xmaj;
    xmaj         = !m_r.dummy && (m_inc_r > INC_ONE);
    x_nxt.xmin   = m_r.xmin;
    x_nxt.xmax   = m_r.xmax;
    x_nxt.inc    = m_inc_r;
    x_nxt.xmaj   = xmaj;
    x_nxt.yneg   = m_r.yneg;
    x_nxt.lin    = m_r.lin;
    x_nxt.xlen   = m_r.xlen;
    x_nxt.yabs   = m_r.yabs;
    x_nxt.w0n    = m_r.w0n;
    x_nxt.w0d    = m_r.w0d;
    x_nxt.w1d    = m_r.w1d;

    if (m_r.dummy) begin
      x_nxt.dxi = m_r.side ? -$signed(ONE_PIX) : 32'sd0;
    end else if (m_r.side) begin
      if (xmaj)
        x_nxt.dxi = m_r.neg ? $signed(HALF_PIX + ONE_PIX) : $signed({2'b0, m_inc_r} - HALF_PIX);
      else if (m_inc_r != '0)
        x_nxt.dxi = m_r.neg ? $signed(ONE_PIX) : 32'sd0;
      else
        x_nxt.dxi = -$signed(ONE_PIX);
    end else begin
      if (xmaj)
        x_nxt.dxi = m_r.neg ? $signed({2'b0, m_inc_r} - HALF_PIX + ONE_PIX) : $signed(HALF_PIX);
      else if (m_inc_r != '0)
        x_nxt.dxi = m_r.neg ? $signed(ONE_PIX) : 32'sd0;
      else
        x_nxt.dxi = 32'sd0;
    end

    if (m_r.dummy) begin
      x_nxt.i0 = '0;
      x_nxt.i1 = '0;
    end else if (xmaj) begin
      x_nxt.i0 = $signed({1'b0, m_r.x0}) - $signed({12'd0, m_r.side});
      x_nxt.i1 = $signed({1'b0, m_r.x1}) - $signed({12'd0, m_r.side});
    end else begin
      x_nxt.i0 = $signed({1'b0, m_r.y0});
      x_nxt.i1 = $signed({1'b0, m_r.y1});
    end
    d           = x_nxt.i1 - x_nxt.i0;
    x_nxt.dneg  = d[12];
    x_nxt.dzero = (d == 13'sd0);
    x_nxt.dabs  = d[12] ? 12'(-d) : d[11:0];
  end

  // ------------------------------------------------------- dividers 2, 3
  always_comb begin
    logic [12:0] st2, st3;
    logic [30:0] num3;
    for (int j = 0; j < D2_STEPS; j++) begin
      if (j == 0) begin
        num3        = {9'd0, x_r.yabs, 10'd0};
        st2         = div_step(12'd0, 1'b1, x_r.dabs);
        st3         = div_step(12'd0, num3[D2_STEPS-1], x_r.xlen);
        e_b_nxt[j]  = x_r;
        e_v_nxt[j]  = x_v_r;
        e_q2_nxt[j] = {30'd0, st2[12]};
        e_q3_nxt[j] = {30'd0, st3[12]};
      end else begin
        num3        = {9'd0, e_b_r[j-1].yabs, 10'd0};
        st2         = div_step(e_r2_r[j-1], 1'b0, e_b_r[j-1].dabs);
        st3         = div_step(e_r3_r[j-1], num3[D2_STEPS-1-j], e_b_r[j-1].xlen);
        e_b_nxt[j]  = e_b_r[j-1];
        e_v_nxt[j]  = e_v_r[j-1];
        e_q2_nxt[j] = {e_q2_r[j-1][29:0], st2[12]};
        e_q3_nxt[j] = {e_q3_r[j-1][29:0], st3[12]};
      end
      e_r2_nxt[j] = st2[11:0];
      e_r3_nxt[j] = st3[11:0];
    end
  end

  // ----------------------------------------------------------- result pack
  always_comb begin
    back_t              b;
    logic signed [31:0] recip;
    logic signed [22:0] cov;
    b = e_b_r[D2_STEPS-1];
    if (b.dzero)     recip = 32'sd0;
    else if (b.dneg) recip = -$signed({1'b0, e_q2_r[D2_STEPS-1]});
    else             recip = $signed({1'b0, e_q2_r[D2_STEPS-1]});
    if (!b.xmaj)     cov = 23'sd0;
    else if (b.yneg) cov = -$signed({1'b0, e_q3_r[D2_STEPS-1][21:0]});
    else             cov = $signed({1'b0, e_q3_r[D2_STEPS-1][21:0]});
    res_data = {b.w1d, b.w0d, b.w0n, b.lin, cov, recip, b.i1, b.i0, b.dxi, b.inc,
                b.xmax, b.xmin};
  end

  // ------------------------------------------------------------ pipe regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      x_v_r  <= 1'b0;
      for (int k = 0; k < D1_STEPS; k++) d1_v_r[k] <= 1'b0;
      for (int j = 0; j < D2_STEPS; j++) e_v_r[j] <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
      m_v_r  <= d1_v_r[D1_STEPS-1];
      x_v_r  <= m_v_r;
      for (int k = 0; k < D1_STEPS; k++) d1_v_r[k] <= d1_v_nxt[k];
      for (int j = 0; j < D2_STEPS; j++) e_v_r[j] <= e_v_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r    <= s0_nxt;
      m_r     <= d1_f_r[D1_STEPS-1];
      m_inc_r <= m_inc_nxt;
      x_r     <= x_nxt;
      for (int k = 0; k < D1_STEPS; k++) begin
        d1_f_r[k]   <= d1_f_nxt[k];
        d1_rem_r[k] <= d1_rem_nxt[k];
        d1_quo_r[k] <= d1_quo_nxt[k];
      end
      for (int j = 0; j < D2_STEPS; j++) begin
        e_b_r[j]  <= e_b_nxt[j];
        e_r2_r[j] <= e_r2_nxt[j];
        e_q2_r[j] <= e_q2_nxt[j];
        e_r3_r[j] <= e_r3_nxt[j];
        e_q3_r[j] <= e_q3_nxt[j];
      end
    end
  end

  // ------------------------------------------------------ output and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
        out_v_r    <= 1'b1;
        skid_v_r   <= 1'b0;
      end else if (e_v_r[D2_STEPS-1]) begin
        out_data_r <= res_data;
        out_v_r    <= 1'b1;
      end else begin
        out_v_r    <= 1'b0;
      end
    end else if (en && e_v_r[D2_STEPS-1]) begin
      // output register is held, catch the finished edge here
      skid_data_r <= res_data;
      skid_v_r    <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for raster_edge_slope_setup. Directed and random edges go in
// through the input stream and every output transfer is compared field by
// field against an in-order queue of predicted edge setups. Both stream sides
// idle at random, with one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------

typedef struct {
  bit        dummy;
  bit [11:0] x0;
  bit [11:0] y0;
  bit [11:0] x1;
  bit [11:0] y1;
  bit [15:0] w0;
  bit [15:0] w1;
  bit        side;
} edge_req_t;

class edge_setup_sb;
  bit [215:0] setup_q[$];
  int         errors;

  // low bit and width of each output field
  int    fld_lo[12] = '{0, 13, 26, 56, 88, 101, 114, 146, 169, 170, 185, 201};
  int    fld_w[12]  = '{13, 13, 30, 32, 13, 13, 32, 23, 1, 15, 16, 15};
  string fld_name[12] = '{"x_min", "x_max", "slope_increment", "dx_initial",
                          "interp_start", "interp_end", "interp_recip",
                          "coverage_increment", "linear_interp", "w_start_num",
                          "w_start_den", "w_end_den"};

  function void report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction

  function bit [215:0] predict_setup(edge_req_t r);
    int xmin, xmax, inc, dxi, i0, i1, irecip, cov, lin, w0n, w0d, w1d;
    int x0, y0, x1, y1, w0, w1, side, xlen, ylen;
    bit neg, xmaj;
    x0 = r.x0; y0 = r.y0; x1 = r.x1; y1 = r.y1;
    w0 = r.w0; w1 = r.w1; side = r.side;
    inc = 0; i0 = 0; i1 = 0; irecip = 0; cov = 0; lin = 1;
    w0n = 0; w0d = 0; w1d = 0; neg = 0;
    if (r.dummy) begin
      xmin = x0 - side;
      xmax = xmin;
      dxi = side ? -32'h40000 : 0;
    end else begin
      if (x1 > x0) begin
        xmin = x0; xmax = x1 - 1;
      end else if (x1 < x0) begin
        xmin = x1; xmax = x0 - 1; neg = 1;
      end else begin
        xmin = x0 - side; xmax = xmin;
      end
      xlen = xmax + 1 - xmin;
      ylen = y1 - y0;
      if (ylen == 0) inc = 0;
      else if (ylen == xlen) inc = 32'h40000;
      else begin
        inc = (x1 - x0) * ((1 << 18) / ylen);
        if (inc < 0) inc = -inc;
      end
      xmaj = inc > 32'h40000;
      if (side) begin
        if (xmaj) dxi = neg ? 32'h60000 : inc - 32'h20000;
        else if (inc != 0) dxi = neg ? 32'h40000 : 0;
        else dxi = -32'h40000;
      end else begin
        if (xmaj) dxi = neg ? inc + 32'h20000 : 32'h20000;
        else if (inc != 0) dxi = neg ? 32'h40000 : 0;
        else dxi = 0;
      end
      if (xmaj) begin
        i0 = x0 - side; i1 = x1 - side;
        cov = (ylen * 1024) / xlen;
      end else begin
        i0 = y0; i1 = y1;
      end
      irecip = (i0 != i1) ? (1 << 30) / (i1 - i0) : 0;
      lin = (w0 == w1) && ((w0 & 'h7E) == 0);
      // odd start w against even end w splits the halving
      if (w0[0] && !w1[0]) begin
        w0n = (w0 - 1) >> 1; w0d = (w0 + 1) >> 1;
      end else begin
        w0n = w0 >> 1; w0d = w0 >> 1;
      end
      w1d = w1 >> 1;
    end
    return {w1d[14:0], w0d[15:0], w0n[14:0], lin[0], cov[22:0], irecip[31:0],
            i1[12:0], i0[12:0], dxi[31:0], inc[29:0], xmax[12:0], xmin[12:0]};
  endfunction

  function void note_edge(edge_req_t r);
    setup_q.push_back(predict_setup(r));
  endfunction

  function void check_setup(bit [215:0] got);
    bit [215:0] exp_v;
    bit [31:0]  g, e, m;
    if (setup_q.size() == 0) begin
      report("output transfer with nothing outstanding");
      return;
    end
    exp_v = setup_q.pop_front();
    for (int i = 0; i < 12; i++) begin
      m = (fld_w[i] == 32) ? 32'hFFFF_FFFF : (32'h1 << fld_w[i]) - 1;
      g = 32'(got >> fld_lo[i]) & m;
      e = 32'(exp_v >> fld_lo[i]) & m;
      if (g !== e) report($sformatf("%s got %h exp %h", fld_name[i], g, e));
    end
  endfunction
endclass

module tb_top;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [215:0] out_tdata;

  edge_setup_sb sb = new();
  bit           hold_req = 0;
  bit           steady = 0;
  int           idle_cycles = 0;

  raster_edge_slope_setup u_top (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_edge(unpack_req(in_tdata, in_tuser));
      if (out_tvalid && out_tready) sb.check_setup(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("raster_edge_slope_setup regression: fail");
        $finish;
      end
    end
  end

  function automatic edge_req_t unpack_req(logic [87:0] d, logic u);
    edge_req_t r;
    r.dummy = u;
    {r.side, r.w1, r.w0, r.y1, r.x1, r.y0, r.x0} = d[80:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 0;
        repeat (300) @(posedge clk);
      end else if (steady) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  task automatic send_edge(edge_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= r.dummy;
    in_tdata  <= {7'b0, r.side, r.w1, r.w0, r.y1, r.x1, r.y0, r.x0};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_fields(bit dm, int x0, int y0, int x1, int y1,
                             int w0, int w1, bit sd);
    edge_req_t r;
    r = '{dm, x0, y0, x1, y1, w0, w1, sd};
    send_edge(r);
  endtask

  function automatic edge_req_t random_edge();
    edge_req_t r;
    int p, dx, dy;
    r.dummy = ($urandom_range(0, 9) == 0);
    r.side  = $urandom_range(0, 1);
    r.x0 = $urandom; r.y0 = $urandom; r.x1 = $urandom; r.y1 = $urandom;
    r.w0 = $urandom; r.w1 = $urandom;
    p = $urandom_range(0, 99);
    if (p < 60) begin
      // short edges reach the slope corner cases far more often
      dx = $urandom_range(0, 64) - 32;
      dy = $urandom_range(0, 16) - 8;
      if (p < 10) dy = dx;
      r.x1 = ((r.x0 + dx) < 0 || (r.x0 + dx) > 4095) ? r.x0 - dx : r.x0 + dx;
      r.y1 = ((r.y0 + dy) < 0 || (r.y0 + dy) > 4095) ? r.y0 - dy : r.y0 + dy;
    end
    p = $urandom_range(0, 99);
    if (p < 25) r.w1 = r.w0 & ~16'h7E;
    if (p < 15) r.w0 = r.w1;
    else if (p < 40) begin
      r.w0[0] = 1; r.w1[0] = 0;
    end
    return r;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes, vertical, flat, diagonal, x-major both ways, dummy both sides
    send_fields(0, 0, 0, 4095, 4095, 0, 65535, 0);
    send_fields(0, 4095, 4095, 0, 0, 65535, 0, 1);
    send_fields(0, 0, 0, 4095, 1, 1, 0, 0);
    send_fields(0, 4095, 0, 0, 1, 65535, 65534, 1);
    send_fields(0, 100, 10, 100, 500, 128, 128, 0);
    send_fields(0, 100, 10, 100, 500, 129, 129, 1);
    send_fields(0, 0, 10, 0, 5, 7, 7, 1);
    send_fields(0, 10, 50, 200, 50, 3, 4, 0);
    send_fields(0, 200, 50, 10, 50, 3, 4, 1);
    send_fields(0, 10, 10, 20, 20, 0, 0, 0);
    send_fields(0, 20, 10, 10, 20, 0, 0, 1);
    send_fields(0, 10, 10, 50, 12, 255, 256, 0);
    send_fields(0, 50, 10, 10, 12, 255, 256, 1);
    send_fields(0, 10, 100, 12, 20, 65535, 65535, 0);
    send_fields(0, 12, 100, 10, 20, 65409, 65409, 1);
    send_fields(0, 0, 4095, 1, 0, 2, 2, 0);
    send_fields(1, 0, 0, 4095, 4095, 65535, 65535, 1);
    send_fields(1, 4095, 4095, 0, 0, 1, 2, 0);
    send_fields(1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(1, 2048, 7, 3, 9, 5, 6, 1);

    for (int i = 0; i < 700; i++) begin
      if (i == 100) hold_req = 1;
      steady = (i >= 300 && i < 380);
      if (i == 500) begin
        in_tvalid <= 0;
        while (sb.setup_q.size() != 0) @(posedge clk);
      end
      send_edge(random_edge());
    end
    in_tvalid <= 0;

    while (sb.setup_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("raster_edge_slope_setup regression: pass");
    else $display("raster_edge_slope_setup regression: fail");
    $finish;
  end
endmodule

/* raster_edge_slope_setup.f */
rtl/res_pkg.sv
rtl/raster_edge_slope_setup.sv
tb/tb_top.sv
